FILE: src/fir_pkg.sv
// Shared types and constants for the FIR filter unit.
// No dependencies; compiled first.
`default_nettype none

package fir_pkg;

    // Default build of the filter
    localparam int FIR_MAX_TAPS    = 32;
    localparam int FIR_SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int TAP_NUM_W  = 6;
    localparam int COEF_IDX_W = 5;

    localparam logic [TAP_NUM_W-1:0] TAP_NUM_RESET = 6'd32;

    // Command codes carried with each input word
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FLUSH,
        ST_DONE
    } fir_state_t;

endpackage

`default_nettype wire

FILE: src/fir_if.sv
// Valid/ready channel interfaces for the FIR filter unit.
// Depends on fir_pkg.
`default_nettype none

interface fir_in_if
    import fir_pkg::*;
#(
    parameter int SAMPLE_BITS = FIR_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [COEF_IDX_W-1:0]         coef_index;
    logic signed [SAMPLE_BITS-1:0] coef_value;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, command, coef_index, coef_value, sample, input ready);
    modport sink   (input valid, command, coef_index, coef_value, sample, output ready);
endinterface

interface fir_out_if
    import fir_pkg::*;
#(
    parameter int SAMPLE_BITS = FIR_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;

    modport source (output valid, filtered, saturated, input ready);
    modport sink   (input valid, filtered, saturated, output ready);
endinterface

`default_nettype wire

FILE: src/fir_filter_unit.sv
// Top level of the direct-form FIR filter unit.
// Depends on fir_pkg and the channel interfaces in fir_if.sv.
`default_nettype none

// Direct-form real FIR filter with one shared multiply-accumulate. A load word
// (command = CMD_LOAD) writes one coefficient; loads to an index at or beyond
// MAX_TAPS are dropped. A filter word pushes its sample into a circular delay
// line held in memory, then the sequencer walks the active taps, reading one
// delay entry and one coefficient per cycle. A filter word is accepted, one
// read is issued per tap, the read/multiply/accumulate pipe drains, and the
// result is rounded and registered once the output register is free. The
// active taps are the tap number register clamped to 1..MAX_TAPS; each store
// has a single read port, so taps are read one at a time. The sum is exact,
// rounded to nearest with ties toward plus infinity, then saturated to
// SAMPLE_BITS; saturated flags clipping. The result sits in an output
// register, so a new word is taken while it waits. Both stores read as zero
// after reset through per-entry valid bits, so no clearing pass is needed.
// The tap number is written through cfg_valid/cfg_ready/cfg_data and is
// sampled when a filter word is taken; write it between filter words.
module fir_filter_unit
    import fir_pkg::*;
#(
    parameter int MAX_TAPS    = FIR_MAX_TAPS,
    parameter int SAMPLE_BITS = FIR_SAMPLE_BITS
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    fir_in_if.sink                    item,
    fir_out_if.source                 result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [TAP_NUM_W-1:0] cfg_data
);

    localparam int AW     = $clog2(MAX_TAPS);
    localparam int FRAC_W = SAMPLE_BITS - 1;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + AW + 1;
    // compare widths wide enough for both the field and MAX_TAPS
    localparam int TC_CW  = (TAP_NUM_W > AW + 1) ? TAP_NUM_W : AW + 1;
    localparam int IX_CW  = (COEF_IDX_W > AW + 1) ? COEF_IDX_W : AW + 1;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    // Storage: delay line (circular) and coefficient store
    logic [SAMPLE_BITS-1:0] dly_mem  [MAX_TAPS];
    logic [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]    dly_vld_reg;
    logic [MAX_TAPS-1:0]    coef_vld_reg;

    // Control state
    fir_state_t             state_reg, state_next;
    logic [TAP_NUM_W-1:0]   tap_num_reg;
    logic [AW-1:0]          head_reg;       // newest sample position
    logic [AW-1:0]          rd_addr_reg;    // delay line read address
    logic [AW-1:0]          tap_reg;        // tap index, also coef address
    logic [AW-1:0]          taps_m1_reg;    // active taps minus one

    // Pipeline
    logic                          rd_valid_reg;
    logic [SAMPLE_BITS-1:0]        dly_q_reg;
    logic [SAMPLE_BITS-1:0]        coef_q_reg;
    logic                          dly_qv_reg;
    logic                          coef_qv_reg;
    logic                          prod_valid_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    // Output register
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        filtered_reg;
    logic                          saturated_reg;

    // Decoded controls
    logic                   in_ready;
    logic                   take_word;
    logic                   do_load;
    logic                   do_sample;
    logic                   last_tap;
    logic                   pipe_empty;
    logic                   out_free;
    logic                   load_out;
    logic [AW-1:0]          new_head;
    logic [AW-1:0]          rd_addr_inc;
    logic [TC_CW-1:0]       tc_ext;
    logic [AW-1:0]          taps_m1;
    logic [IX_CW-1:0]       idx_ext;
    logic                   idx_ok;
    logic [AW-1:0]          coef_addr;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [SAMPLE_BITS-1:0] mul_b;
    logic signed [ACC_W-1:0]       rnd;
    logic [ACC_W-FRAC_W-SAMPLE_BITS:0] rnd_hi;
    logic                          sat;
    logic [SAMPLE_BITS-1:0]        res;

    assign cfg_ready = 1'b1;

    assign take_word = item.valid && in_ready;
    assign do_load   = take_word && (item.command == CMD_LOAD);
    assign do_sample = take_word && (item.command == CMD_FILTER);

    assign new_head    = (head_reg == '0) ? LAST_ADDR : head_reg - AW'(1);
    assign rd_addr_inc = (rd_addr_reg == LAST_ADDR) ? '0 : rd_addr_reg + AW'(1);
    assign last_tap    = (tap_reg == taps_m1_reg);
    assign pipe_empty  = !rd_valid_reg && !prod_valid_reg;
    assign out_free    = !out_valid_reg || result.ready;

    // Active tap count, clamped to 1..MAX_TAPS, kept as count minus one
    always_comb
    begin
        tc_ext = TC_CW'(tap_num_reg);
        if (tc_ext == '0)
            taps_m1 = '0;
        else if (tc_ext > TC_CW'(MAX_TAPS))
            taps_m1 = LAST_ADDR;
        else
            taps_m1 = AW'(tc_ext - TC_CW'(1));
    end

    // Coefficient load address check
    assign idx_ext   = IX_CW'(item.coef_index);
    assign idx_ok    = idx_ext < IX_CW'(MAX_TAPS);
    assign coef_addr = idx_ext[AW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (do_sample)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                if (last_tap)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (pipe_empty)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_READ:  ;
            ST_FLUSH: ;
            ST_DONE:  load_out = out_free;
            default:  ;
        endcase
    end

    assign item.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tap_num_reg <= TAP_NUM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                tap_num_reg <= cfg_data;
        end
    end

    // Memory writes
    always_ff @(posedge clk)
    begin
        if (do_load && idx_ok)
            coef_mem[coef_addr] <= item.coef_value;
        if (do_sample)
            dly_mem[new_head] <= item.sample;
    end

    // Valid bits: unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg <= '0;
            dly_vld_reg  <= '0;
        end
        else
        begin
            if (do_load && idx_ok)
                coef_vld_reg[coef_addr] <= 1'b1;
            if (do_sample)
                dly_vld_reg[new_head] <= 1'b1;
        end
    end

    // Tap walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            rd_addr_reg <= '0;
            tap_reg     <= '0;
            taps_m1_reg <= '0;
        end
        else if (do_sample)
        begin
            head_reg    <= new_head;
            rd_addr_reg <= new_head;
            tap_reg     <= '0;
            taps_m1_reg <= taps_m1;
        end
        else if (state_reg == ST_READ)
        begin
            rd_addr_reg <= rd_addr_inc;
            tap_reg     <= tap_reg + AW'(1);
        end
    end

    // Synchronous memory reads, one tap per cycle
    always_ff @(posedge clk)
    begin
        dly_q_reg   <= dly_mem[rd_addr_reg];
        coef_q_reg  <= coef_mem[tap_reg];
        dly_qv_reg  <= dly_vld_reg[rd_addr_reg];
        coef_qv_reg <= coef_vld_reg[tap_reg];
    end

    assign mul_a = dly_qv_reg  ? $signed(dly_q_reg)  : '0;
    assign mul_b = coef_qv_reg ? $signed(coef_q_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= (state_reg == ST_READ);
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // Multiply, then accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (do_sample)
            acc_reg <= '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    // Round half up, drop fraction, saturate
    always_comb
    begin
        rnd    = acc_reg + (ACC_W'(1) << (FRAC_W - 1));
        rnd_hi = rnd[ACC_W-1:FRAC_W+SAMPLE_BITS-1];
        sat    = !((&rnd_hi) || !(|rnd_hi));
        if (!sat)
            res = rnd[FRAC_W+SAMPLE_BITS-1:FRAC_W];
        else if (rnd[ACC_W-1])
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            filtered_reg  <= res;
            saturated_reg <= sat;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.filtered  = $signed(filtered_reg);
    assign result.saturated = saturated_reg;

endmodule

`default_nettype wire

FILE: test/fir_filter_unit_tb.sv
// Self-checking testbench for fir_filter_unit: coefficient loads, filter words, tap number.
// Depends on fir_pkg, the channel interfaces in fir_if.sv and fir_filter_unit.

module fir_filter_unit_tb;
    import fir_pkg::*;

    localparam int SW           = FIR_SAMPLE_BITS;
    localparam int NTAPS        = FIR_MAX_TAPS;
    localparam int DRAIN_CYCLES = 80;      // idle margin after the last result
    localparam int PHASES       = 13;
    localparam int PHASE_WORDS  = 41;

    // One input word plus, for directed rows, the expected result typed in
    typedef struct packed {
        logic                  cmd;
        logic [COEF_IDX_W-1:0] idx;
        logic signed [SW-1:0]  coef;
        logic signed [SW-1:0]  smp;
        logic                  typed;
        logic signed [SW-1:0]  exp_filtered;
        logic                  exp_sat;
    } stim_word_t;

    typedef struct packed {
        logic signed [SW-1:0] filtered;
        logic                 saturated;
    } fir_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TAP_NUM_W-1:0] cfg_data;

    fir_in_if  item_ch ();
    fir_out_if result_ch ();

    fir_filter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Shadow of the filter state: newest sample at tap 0
    logic signed [SW-1:0] tap_history [NTAPS];
    logic signed [SW-1:0] coef_bank   [NTAPS];
    logic [TAP_NUM_W-1:0] active_taps;

    fir_result_t expected_outputs [$];
    int          error_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    // Directed words. Typed expectations assume the tap number at its reset value of 32.
    stim_word_t directed_words [0:15] = '{
        // all coefficients zero after reset: output zero for full-scale input
        '{CMD_FILTER, 5'd0,  16'sd0,      16'sd32767,  1'b1, 16'sd0,      1'b0},
        '{CMD_FILTER, 5'd0,  16'sd0,      -16'sd32768, 1'b1, 16'sd0,      1'b0},
        // load with a sample field that must be ignored
        '{CMD_LOAD,   5'd0,  16'sd32767,  16'sd21845,  1'b0, 16'sd0,      1'b0},
        // max * max rounds down to 32766; coef fields ignored on a filter word
        '{CMD_FILTER, 5'd31, -16'sd1,     16'sd32767,  1'b1, 16'sd32766,  1'b0},
        '{CMD_LOAD,   5'd0,  -16'sd32768, 16'sd0,      1'b0, 16'sd0,      1'b0},
        // min * min = +1.0, clips high
        '{CMD_FILTER, 5'd0,  16'sd0,      -16'sd32768, 1'b1, 16'sd32767,  1'b1},
        // -1.0 * max gives exactly -32767, no clipping
        '{CMD_FILTER, 5'd0,  16'sd0,      16'sd32767,  1'b1, -16'sd32767, 1'b0},
        '{CMD_LOAD,   5'd1,  -16'sd32768, 16'sd0,      1'b0, 16'sd0,      1'b0},
        // two taps at -1.0 * max: clips low
        '{CMD_FILTER, 5'd0,  16'sd0,      16'sd32767,  1'b1, -16'sd32768, 1'b1},
        '{CMD_LOAD,   5'd0,  16'sd1,      16'sd0,      1'b0, 16'sd0,      1'b0},
        '{CMD_LOAD,   5'd1,  16'sd0,      16'sd0,      1'b0, 16'sd0,      1'b0},
        // +0.5 LSB tie goes up to 1
        '{CMD_FILTER, 5'd0,  16'sd0,      16'sd16384,  1'b1, 16'sd1,      1'b0},
        // -0.5 LSB tie goes up to 0
        '{CMD_FILTER, 5'd0,  16'sd0,      -16'sd16384, 1'b1, 16'sd0,      1'b0},
        // top index
        '{CMD_LOAD,   5'd31, 16'sd32767,  -16'sd1,     1'b0, 16'sd0,      1'b0},
        '{CMD_LOAD,   5'd30, -16'sd32768, -16'sd1,     1'b0, 16'sd0,      1'b0},
        '{CMD_FILTER, 5'd17, 16'sd4660,   -16'sd1,     1'b0, 16'sd0,      1'b0}
    };

    // Tap number per random phase: clamp cases 0 and > MAX_TAPS included
    logic [TAP_NUM_W-1:0] phase_taps [PHASES] = '{
        6'd1, 6'd0, 6'd63, 6'd33, 6'd2, 6'd32, 6'd16, 6'd31, 6'd5, 6'd0, 6'd1, 6'd32, 6'd63
    };

    // Clock: 20 time units
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

    // Shift one sample into the history and form the rounded, clipped sum
    // over the active taps. Sum is exact in 64 bits (32 * 2^30 fits easily).
    function automatic fir_result_t filter_step(input logic signed [SW-1:0] smp);
        logic signed [63:0] acc;
        int                 n;
        fir_result_t        r;
        for (int k = NTAPS - 1; k > 0; k--)
            tap_history[k] = tap_history[k-1];
        tap_history[0] = smp;
        n = (active_taps == 0) ? 1 : ((active_taps > NTAPS) ? NTAPS : int'(active_taps));
        acc = 64'sd1 <<< (SW - 2);             // half an LSB: ties go toward +inf
        for (int k = 0; k < n; k++)
            acc = acc + coef_bank[k] * tap_history[k];
        acc = acc >>> (SW - 1);
        if (acc > ((64'sd1 <<< (SW - 1)) - 1))
        begin
            r.filtered  = {1'b0, {(SW-1){1'b1}}};
            r.saturated = 1'b1;
        end
        else if (acc < -(64'sd1 <<< (SW - 1)))
        begin
            r.filtered  = {1'b1, {(SW-1){1'b0}}};
            r.saturated = 1'b1;
        end
        else
        begin
            r.filtered  = acc[SW-1:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    // Called at the accepting edge: update shadow state, queue the expected word
    function automatic void track_word(input stim_word_t w);
        fir_result_t r;
        if (w.cmd == CMD_LOAD)
            coef_bank[w.idx] = w.coef;        // index is 5 bits, always < MAX_TAPS
        else
        begin
            r = filter_step(w.smp);
            if (w.typed)
                r = '{w.exp_filtered, w.exp_sat};
            expected_outputs.push_back(r);
        end
    endfunction

    // Random word: about a quarter loads. Coefficients, unless set to full scale,
    // get a random right shift so sums land both in range and in saturation.
    function automatic stim_word_t random_word();
        stim_word_t w;
        w.cmd  = ($urandom_range(3) == 0) ? CMD_LOAD : CMD_FILTER;
        w.idx  = COEF_IDX_W'($urandom_range(NTAPS - 1));
        w.coef = SW'($urandom);
        if ($urandom_range(7) == 0)
            w.coef = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        else
            w.coef = w.coef >>> $urandom_range(SW - 1);
        w.smp  = SW'($urandom);
        if ($urandom_range(7) == 0)
            w.smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        w.typed        = 1'b0;
        w.exp_filtered = '0;
        w.exp_sat      = 1'b0;
        return w;
    endfunction

    // Entered and left at a falling edge. valid stays high after acceptance
    // so back-to-back words never drop it within one step.
    task automatic send_word(input stim_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.command    <= w.cmd;
        item_ch.coef_index <= w.idx;
        item_ch.coef_value <= w.coef;
        item_ch.sample     <= w.smp;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        track_word(w);
        @(negedge clk);
    endtask

    // Let every expected word come back, then wait DRAIN_CYCLES more before
    // touching the register.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (expected_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_tap_num(input logic [TAP_NUM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        active_taps = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, changed at the falling edge
    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        fir_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result word, expected none, got filtered %0d sat %0b",
                         $time, result_ch.filtered, result_ch.saturated);
            end
            else
            begin
                want = expected_outputs.pop_front();
                if (result_ch.filtered !== want.filtered)
                begin
                    error_count++;
                    $display("%0t: filtered expected %0d, actual %0d",
                             $time, want.filtered, result_ch.filtered);
                end
                if (result_ch.saturated !== want.saturated)
                begin
                    error_count++;
                    $display("%0t: saturated expected %0b, actual %0b",
                             $time, want.saturated, result_ch.saturated);
                end
            end
        end
    end

    initial
    begin
        error_count   = 0;
        send_idle_pct = 36;
        recv_idle_pct = 50;
        active_taps   = TAP_NUM_RESET;
        for (int k = 0; k < NTAPS; k++)
        begin
            tap_history[k] = '0;
            coef_bank[k]   = '0;
        end

        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        item_ch.valid      = 1'b0;
        item_ch.command    = CMD_FILTER;
        item_ch.coef_index = '0;
        item_ch.coef_value = '0;
        item_ch.sample     = '0;
        result_ch.ready    = 1'b0;

        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, at the reset tap number
        foreach (directed_words[k])
            send_word(directed_words[k]);

        // Random part: one tap number per phase; idling mode shifts in three steps:
        // receiver-heavy, then sender-heavy, then none at all
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 50;
            end
            else if (p < 8)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            write_tap_num(phase_taps[p]);
            repeat (PHASE_WORDS)
                send_word(random_word());
        end

        wait_idle();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
src/fir_pkg.sv
src/fir_if.sv
src/fir_filter_unit.sv
test/fir_filter_unit_tb.sv
